@@ hw/rtl/pcfd_pkg.sv @@
package pcfd_pkg;

    typedef struct packed {
        logic        operation;
        logic [31:0] error_value;
        logic [31:0] time_step;
        logic [31:0] derivative_signal;
    } t_in_item;

    typedef struct packed {
        logic [31:0] drive_value;
        logic        step_invalid;
    } t_out_item;

    localparam logic [2:0] REG_GAIN_P      = 3'd0;
    localparam logic [2:0] REG_GAIN_I      = 3'd1;
    localparam logic [2:0] REG_GAIN_D      = 3'd2;
    localparam logic [2:0] REG_INT_LIMIT   = 3'd3;
    localparam logic [2:0] REG_INT_DBAND   = 3'd4;
    localparam logic [2:0] REG_ALPHA       = 3'd5;
    localparam logic [2:0] REG_OUT_LOW     = 3'd6;
    localparam logic [2:0] REG_OUT_HIGH    = 3'd7;

    localparam logic [16:0] Q_ONE = 17'h10000;
    localparam int DIV_STEPS = 49;

    // Datapath operation selected by the controller.
    typedef enum logic [3:0] {
        OP_NONE    = 4'd0,
        OP_LOAD    = 4'd1,
        OP_MUL_P   = 4'd2,
        OP_MUL_INC = 4'd3,
        OP_ACC     = 4'd4,
        OP_MUL_I   = 4'd5,
        OP_DIV_ST  = 4'd6,
        OP_DIV_IT  = 4'd7,
        OP_MIX_A   = 4'd8,
        OP_MIX_B   = 4'd9,
        OP_MIX_END = 4'd10,
        OP_MUL_D   = 4'd11,
        OP_SUM     = 4'd12,
        OP_CLAMP   = 4'd13,
        OP_CLEAR   = 4'd14,
        OP_INVALID = 4'd15
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic is_clear;
        logic dt_zero;
        logic first;
        logic div_done;
    } t_status;

    function automatic logic [31:0] sat32(input logic signed [65:0] x);
        logic [31:0] r;
        if (x > 66'sd2147483647) begin
            r = 32'h7fff_ffff;
        end else if (x < -66'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/pcfd_ctrl.sv @@
module pcfd_ctrl import pcfd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_DEC   = 12'b0000_0000_0010,
        S_P     = 12'b0000_0000_0100,
        S_INC   = 12'b0000_0000_1000,
        S_ACC   = 12'b0000_0001_0000,
        S_I     = 12'b0000_0010_0000,
        S_DIV   = 12'b0000_0100_0000,
        S_MIXA  = 12'b0000_1000_0000,
        S_MIXB  = 12'b0001_0000_0000,
        S_D     = 12'b0010_0000_0000,
        S_SUM   = 12'b0100_0000_0000,
        S_OUT   = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_sub, n_sub;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state  = r_state;
        n_sub    = r_sub;
        o_cmd.op = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DEC;
                end
            end
            S_DEC: begin
                if (i_status.is_clear) begin
                    o_cmd.op = OP_CLEAR;
                    n_state  = S_OUT;
                end else if (i_status.dt_zero) begin
                    o_cmd.op = OP_INVALID;
                    n_state  = S_OUT;
                end else begin
                    o_cmd.op = OP_MUL_P;
                    n_state  = S_INC;
                end
            end
            S_INC: begin
                o_cmd.op = OP_MUL_INC;
                n_state  = S_ACC;
            end
            S_ACC: begin
                o_cmd.op = OP_ACC;
                n_state  = S_I;
            end
            S_I: begin
                o_cmd.op = OP_MUL_I;
                n_sub    = 1'b0;
                n_state  = i_status.first ? S_D : S_DIV;
            end
            S_DIV: begin
                if (!r_sub) begin
                    o_cmd.op = OP_DIV_ST;
                    n_sub    = 1'b1;
                end else if (i_status.div_done) begin
                    o_cmd.op = OP_MIX_A;
                    n_state  = S_MIXA;
                end else begin
                    o_cmd.op = OP_DIV_IT;
                end
            end
            S_MIXA: begin
                o_cmd.op = OP_MIX_B;
                n_state  = S_MIXB;
            end
            S_MIXB: begin
                o_cmd.op = OP_MIX_END;
                n_state  = S_D;
            end
            S_D: begin
                o_cmd.op = OP_MUL_D;
                n_state  = S_SUM;
            end
            S_SUM: begin
                o_cmd.op = OP_SUM;
                n_state  = S_P;
            end
            S_P: begin
                o_cmd.op = OP_CLAMP;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sub   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sub   <= n_sub;
        end
    end

endmodule

@@ hw/rtl/pcfd_datapath.sv @@
module pcfd_datapath import pcfd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  t_in_item    i_in,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    output t_out_item   o_out
);

    logic [31:0] r_gain_p, r_gain_i, r_gain_d, r_out_low, r_out_high;
    logic [30:0] r_int_limit, r_int_dband;
    logic [16:0] r_alpha;

    logic [31:0] r_integral, r_prev, r_slope;
    logic        r_first;

    t_in_item    r_in;
    logic [31:0] r_p, r_i, r_d, r_inc, r_raw, r_drive;
    logic        r_invalid;
    logic signed [63:0] r_mix;

    // Restoring divider: |diff| * 2^16 (49 bits) by dt.
    logic [48:0] r_quo;
    logic [32:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_neg;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_y;
    logic signed [63:0] mul_sh;
    logic [31:0]        mul_sat;

    always_comb begin
        mul_a = r_gain_p;
        mul_b = r_in.error_value;
        case (i_cmd.op)
            OP_MUL_I: begin
                mul_a = r_gain_i;
                mul_b = r_integral;
            end
            OP_MUL_D: begin
                mul_a = r_gain_d;
                mul_b = r_first ? 32'd0 : r_slope;
            end
            default: begin
                mul_a = r_gain_p;
                mul_b = r_in.error_value;
            end
        endcase
        mul_y   = mul_a * mul_b;
        mul_sh  = mul_y >>> 16;
        mul_sat = sat32({{2{mul_sh[63]}}, mul_sh});
    end

    logic signed [63:0] inc_y, inc_sh;
    assign inc_y  = $signed(r_in.error_value) * $signed({1'b0, r_in.time_step});
    assign inc_sh = inc_y >>> 16;

    logic [31:0] err_mag;
    assign err_mag = r_in.error_value[31] ? (~r_in.error_value + 32'd1) : r_in.error_value;

    logic signed [33:0] acc_sum;
    logic [31:0]        acc_sat, acc_cl;
    always_comb begin
        acc_sum = $signed({{2{r_integral[31]}}, r_integral})
                + $signed({{2{r_inc[31]}}, r_inc});
        acc_sat = sat32({{32{acc_sum[33]}}, acc_sum});
        acc_cl  = acc_sat;
        if ($signed(acc_sat) > $signed({1'b0, r_int_limit})) begin
            acc_cl = {1'b0, r_int_limit};
        end
        if ($signed(acc_sat) < -$signed({1'b0, r_int_limit})) begin
            acc_cl = -{1'b0, r_int_limit};
        end
    end

    logic signed [32:0] diff;
    logic [32:0]        diff_mag;
    assign diff     = $signed({r_in.derivative_signal[31], r_in.derivative_signal})
                    - $signed({r_prev[31], r_prev});
    assign diff_mag = diff[32] ? (~diff + 33'd1) : diff;

    logic [33:0] rem_sh;
    logic [33:0] rem_sub;
    assign rem_sh  = {r_rem, r_quo[48]};
    assign rem_sub = rem_sh - {2'b00, r_in.time_step};

    logic [16:0] alpha_c;
    assign alpha_c = (r_alpha > Q_ONE) ? Q_ONE : r_alpha;

    logic signed [49:0] q_signed;
    assign q_signed = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});

    // The new slope weighted by alpha is registered first; the old slope weighted
    // by the complement is added in the following cycle.
    logic signed [49:0] mix_prod;
    always_comb begin
        if (i_cmd.op == OP_MIX_B) begin
            mix_prod = $signed(r_raw) * $signed({1'b0, alpha_c});
        end else begin
            mix_prod = $signed(r_slope) * $signed({1'b0, Q_ONE - alpha_c});
        end
    end

    logic signed [63:0] mix_next;
    assign mix_next = r_mix + {{14{mix_prod[49]}}, mix_prod};

    logic signed [63:0] mix_sh;
    assign mix_sh = mix_next >>> 16;

    logic signed [33:0] tot;
    logic [31:0]        tot_sat, tot_cl;
    always_comb begin
        tot = $signed({{2{r_p[31]}}, r_p}) + $signed({{2{r_i[31]}}, r_i})
            + $signed({{2{r_d[31]}}, r_d});
        tot_sat = sat32({{32{tot[33]}}, tot});
        tot_cl  = tot_sat;
        if ($signed(tot_cl) < $signed(r_out_low)) begin
            tot_cl = r_out_low;
        end
        if ($signed(tot_cl) > $signed(r_out_high)) begin
            tot_cl = r_out_high;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p    <= '0;
            r_gain_i    <= '0;
            r_gain_d    <= '0;
            r_int_limit <= '1;
            r_int_dband <= '0;
            r_alpha     <= Q_ONE;
            r_out_low   <= 32'h8000_0000;
            r_out_high  <= 32'h7fff_ffff;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_GAIN_P:    r_gain_p    <= i_cfg_data;
                REG_GAIN_I:    r_gain_i    <= i_cfg_data;
                REG_GAIN_D:    r_gain_d    <= i_cfg_data;
                REG_INT_LIMIT: r_int_limit <= i_cfg_data[30:0];
                REG_INT_DBAND: r_int_dband <= i_cfg_data[30:0];
                REG_ALPHA:     r_alpha     <= i_cfg_data[16:0];
                REG_OUT_LOW:   r_out_low   <= i_cfg_data;
                REG_OUT_HIGH:  r_out_high  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral <= '0;
            r_prev     <= '0;
            r_slope    <= '0;
            r_first    <= 1'b1;
        end else begin
            case (i_cmd.op)
                OP_CLEAR: begin
                    r_integral <= '0;
                    r_prev     <= '0;
                    r_slope    <= '0;
                    r_first    <= 1'b1;
                end
                OP_ACC: begin
                    if ({1'b0, err_mag} > {2'b00, r_int_dband}) begin
                        r_integral <= acc_cl;
                    end
                end
                OP_MIX_END: r_slope <= sat32({{2{mix_sh[63]}}, mix_sh});
                OP_CLAMP: begin
                    r_first <= 1'b0;
                    r_prev  <= r_in.derivative_signal;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD:    r_in <= i_in;
            OP_MUL_P:   r_p <= mul_sat;
            OP_MUL_INC: r_inc <= sat32({{2{inc_sh[63]}}, inc_sh});
            OP_MUL_I:   r_i <= mul_sat;
            OP_MUL_D:   r_d <= mul_sat;
            OP_DIV_ST: begin
                r_quo <= {diff_mag, 16'd0};
                r_rem <= '0;
                r_cnt <= '0;
                r_neg <= diff[32];
            end
            OP_DIV_IT: begin
                if (!rem_sub[33]) begin
                    r_rem <= rem_sub[32:0];
                    r_quo <= {r_quo[47:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[32:0];
                    r_quo <= {r_quo[47:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
            end
            OP_MIX_A: begin
                r_raw <= sat32({{16{q_signed[49]}}, q_signed});
            end
            OP_MIX_B:   r_mix <= {{14{mix_prod[49]}}, mix_prod};
            OP_CLAMP: begin
                r_drive   <= tot_cl;
                r_invalid <= 1'b0;
            end
            OP_CLEAR: begin
                r_drive   <= '0;
                r_invalid <= 1'b0;
            end
            OP_INVALID: begin
                r_drive   <= '0;
                r_invalid <= 1'b1;
            end
            default: ;
        endcase
    end

    assign o_status.is_clear = r_in.operation;
    assign o_status.dt_zero  = (r_in.time_step == 32'd0);
    assign o_status.first    = r_first;
    assign o_status.div_done = (r_cnt == 6'(DIV_STEPS));

    assign o_out.drive_value  = r_drive;
    assign o_out.step_invalid = r_invalid;

endmodule

@@ hw/rtl/pid_controller_filtered_derivative.sv @@
// A clear or zero time step goes from decode straight to the result beat. The first update
// after a clear runs the P, increment, accumulate, I, D, sum and clamp steps; other updates
// also run the divider and two slope mixing steps before D. One item at a time: a new item
// is taken only after the result beat is taken, and the beat is held while stalled. The
// 49-step restoring divider that forms the slope sets the update time. Reset is synchronous
// and active low; it resets the configuration, control state and integral/slope history.
module pid_controller_filtered_derivative import pcfd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data
);

    t_cmd    cmd;
    t_status status;

    pcfd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    pcfd_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out       (o_out_data)
    );

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while result pending");

    a_inv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.step_invalid |-> o_out_data.drive_value == 32'd0)
        else $error("invalid step with nonzero drive");

endmodule
